@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of the decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check with an active-low reset that disables it.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/zrld_pkg.sv @@
// Types and constants of the zero run-length decoder.
`default_nettype none

package zrld_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 20;
  localparam int unsigned FRAME_W  = 20;
  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

  // One run descriptor as it leaves the block.
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic [LEN_W-1:0]  len;
    logic              frame_end;
  } result_t;

  // Results of one decoded source byte, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } dec_t;

endpackage

`default_nettype wire

@@ src/zero_run_length_decoder_core.sv @@
// Zero run-length decoder: one source byte a cycle in while the queue has room, one run
// descriptor a cycle out while the receiver does not stall. A byte is taken into an
// input register, decoded against the frame state and written into a four-entry result
// queue once the queue has room for its results, and its first result is then offered
// from the queue. Bytes go in at one a cycle as long as the queue holds no more than two
// results; a final byte that also yields a data run gives two results, which the queue
// absorbs. The frame size is taken as-is from the configuration register and must be
// written while no byte is in flight.
`default_nettype none

module zero_run_length_decoder_core import zrld_pkg::*; #(
  parameter int unsigned SIZE_BITS = 20
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [FRAME_W-1:0] cfg_data_i,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [BYTE_W-1:0]  src_byte_i,
  input  wire logic               src_last_i,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [BYTE_W-1:0]       pixel_value_o,
  output logic [LEN_W-1:0]        run_length_o,
  output logic                    frame_end_o
);

  logic [FRAME_W-1:0] size_cfg_q;
  logic               in_vld_q;
  logic [BYTE_W-1:0]  byte_q;
  logic               last_q;
  logic               room2;
  logic               advance;
  logic               accept;
  logic               pop;
  dec_t               dec;
  result_t            head;

  // Configuration register, always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_cfg_q <= '0;
    end else if (cfg_valid && cfg_ready) begin
      size_cfg_q <= cfg_data_i;
    end
  end

  // Input register: hold the request until the queue has room for its results.
  assign advance  = in_vld_q & room2;
  assign in_stall = in_vld_q & ~room2;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= src_byte_i;
      last_q <= src_last_i;
    end
  end

  zrld_decode #(
    .SIZE_BITS(SIZE_BITS)
  ) u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .src_byte_i(byte_q),
    .src_last_i(last_q),
    .size_cfg_i(size_cfg_q),
    .dec_o     (dec)
  );

  // Drop a result from the queue when the receiver takes it.
  assign pop = out_valid & ~out_stall;

  zrld_result_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (advance),
    .dec_i  (dec),
    .pop_i  (pop),
    .room2_o(room2),
    .valid_o(out_valid),
    .head_o (head)
  );

  assign pixel_value_o = head.value;
  assign run_length_o  = head.len;
  assign frame_end_o   = head.frame_end;

endmodule

`default_nettype wire

@@ src/zrld_decode.sv @@
// Per-frame decode state and the combinational decode of one source byte.
`default_nettype none

module zrld_decode import zrld_pkg::*; #(
  parameter int unsigned SIZE_BITS = 20
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               advance_i,
  input  wire logic [BYTE_W-1:0]  src_byte_i,
  input  wire logic               src_last_i,
  input  wire logic [FRAME_W-1:0] size_cfg_i,
  output dec_t                    dec_o
);

  logic [SIZE_BITS-1:0] pe_q, pe_d, pe_mid;
  logic                 cp_q, cp_d, cp_mid;
  logic                 ff_q, ff_d, ff_mid;

  logic [SIZE_BITS+FRAME_W-1:0] size_wide;
  logic [SIZE_BITS-1:0]         size;
  logic [SIZE_BITS-1:0]         room;
  logic [SIZE_BITS-1:0]         b_ext;
  logic [SIZE_BITS-1:0]         run;
  logic [SIZE_BITS-1:0]         data_len;
  logic [SIZE_BITS-1:0]         added;
  logic [SIZE_BITS-1:0]         pad;
  logic                         reached;
  logic                         full;
  logic                         data_vld;
  logic [BYTE_W-1:0]            data_val;
  logic [SIZE_BITS+LEN_W-1:0]   data_len_wide;
  logic [SIZE_BITS+LEN_W-1:0]   pad_wide;
  result_t                      data_res;
  result_t                      end_res;

  // Take the frame size at the counter width.
  assign size_wide = {{SIZE_BITS{1'b0}}, size_cfg_i};
  assign size      = size_wide[SIZE_BITS-1:0];
  assign reached   = (pe_q >= size);
  assign full      = ff_q | reached;
  assign room      = size - pe_q;
  assign b_ext     = SIZE_BITS'(src_byte_i);
  assign run       = (b_ext < room) ? b_ext : room;

  // Decode the byte against the current frame state.
  always_comb begin
    pe_mid   = pe_q;
    cp_mid   = cp_q;
    ff_mid   = ff_q;
    data_vld = 1'b0;
    data_val = ZERO_BYTE;
    data_len = '0;
    if (!full) begin
      if (cp_q) begin
        cp_mid = 1'b0;
        if (run != '0) begin
          data_vld = 1'b1;
          data_len = run;
          pe_mid   = pe_q + run;
          ff_mid   = ff_q | (run == room);
        end
      end else if (src_byte_i == ZERO_BYTE) begin
        cp_mid = ~src_last_i;
      end else begin
        data_vld = 1'b1;
        data_val = src_byte_i;
        data_len = SIZE_BITS'(1);
        pe_mid   = pe_q + SIZE_BITS'(1);
        ff_mid   = ff_q | (room == SIZE_BITS'(1));
      end
    end
  end

  // Padding up to the frame size, saturating when the size lies below the count.
  assign added = data_vld ? data_len : '0;
  assign pad   = reached ? '0 : (room - added);

  assign data_len_wide = {{LEN_W{1'b0}}, data_len};
  assign pad_wide      = {{LEN_W{1'b0}}, pad};

  always_comb begin
    data_res.value     = data_val;
    data_res.len       = data_len_wide[LEN_W-1:0];
    data_res.frame_end = 1'b0;
    end_res.value      = ZERO_BYTE;
    end_res.len        = pad_wide[LEN_W-1:0];
    end_res.frame_end  = 1'b1;
  end

  // Order the results: data run first, end marker last.
  always_comb begin
    dec_o.second = end_res;
    if (src_last_i) begin
      dec_o.count = data_vld ? 2'd2 : 2'd1;
      dec_o.first = data_vld ? data_res : end_res;
    end else begin
      dec_o.count = data_vld ? 2'd1 : 2'd0;
      dec_o.first = data_res;
    end
  end

  // Clear the frame state after the final byte.
  always_comb begin
    if (src_last_i) begin
      pe_d = '0;
      cp_d = 1'b0;
      ff_d = 1'b0;
    end else begin
      pe_d = pe_mid;
      cp_d = cp_mid;
      ff_d = ff_mid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pe_q <= '0;
      cp_q <= 1'b0;
      ff_q <= 1'b0;
    end else if (advance_i) begin
      pe_q <= pe_d;
      cp_q <= cp_d;
      ff_q <= ff_d;
    end
  end

endmodule

`default_nettype wire

@@ src/zrld_result_fifo.sv @@
// Four-entry result queue taking up to two run descriptors a cycle.
`default_nettype none

module zrld_result_fifo import zrld_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  dec_t      dec_i,
  input  wire logic pop_i,
  output logic      room2_o,
  output logic      valid_o,
  output result_t   head_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  result_t          mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   cnt_q, cnt_d;
  logic [1:0]       n_push;
  logic [PTR_W-1:0] wr_ptr_nx;

  assign n_push    = push_i ? dec_i.count : 2'd0;
  assign wr_ptr_nx = wr_ptr_q + PTR_W'(1);
  assign room2_o   = (cnt_q <= (PTR_W+1)'(DEPTH - 2));
  assign valid_o   = (cnt_q != '0);
  assign head_o    = mem_q[rd_ptr_q];

  // Advance pointers and fill level.
  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(n_push);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop_i);
    cnt_d    = cnt_q + (PTR_W+1)'(n_push) - (PTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the new results in delivery order.
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_ptr_q] <= dec_i.first;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_ptr_nx] <= dec_i.second;
    end
  end

endmodule

`default_nettype wire

@@ src/zrld_checker.sv @@
// Port-level checks of the decoder and their binding to the top level.
`default_nettype none
`include "assert_macros.svh"

module zrld_checker import zrld_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [BYTE_W-1:0]  pixel_value_o,
  input wire logic [LEN_W-1:0]   run_length_o,
  input wire logic               frame_end_o
);

  // A stalled result stays offered.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && out_stall, out_valid, "result dropped while stalled")

  // A literal pixel is a single pixel and never closes the frame.
  `ASSERT_CLK(a_literal_shape, clk_i, rst_ni, !out_valid || pixel_value_o == ZERO_BYTE || (run_length_o == LEN_W'(1) && !frame_end_o), "malformed literal run")

  // Only the end marker may be empty.
  `ASSERT_CLK(a_empty_is_end, clk_i, rst_ni, !out_valid || run_length_o != '0 || frame_end_o, "empty data run")

  // The end marker always carries value zero.
  `ASSERT_CLK(a_end_zero, clk_i, rst_ni, !out_valid || !frame_end_o || pixel_value_o == ZERO_BYTE, "end marker with non-zero value")

endmodule

bind zero_run_length_decoder_core zrld_checker u_zrld_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .pixel_value_o(pixel_value_o),
  .run_length_o (run_length_o),
  .frame_end_o  (frame_end_o)
);

`default_nettype wire
